>>> rtl/irwh_pkg.sv
// Shared constants, command codes and control types of the interpolating ring write head.
`timescale 1ns / 1ps
package irwh_pkg;

  localparam int RING_DEPTH = 65536;
  localparam int ADDR_W     = $clog2(RING_DEPTH);
  localparam int SAMPLE_W   = 24;
  localparam int LEN_W      = 17;
  localparam int GAIN_W     = 16;
  localparam int CNT_W      = 16;
  localparam int SUM_W      = 40;
  localparam int DIV_W      = 40;
  localparam int DIVR_W     = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;
  localparam int CMD_W      = 4;

  localparam logic [GAIN_W-1:0] FB_MAX    = 16'd62259;
  localparam logic [CNT_W-1:0]  CNT_MAX   = 16'hFFFF;
  localparam logic [LEN_W-1:0]  LEN_MIN   = 17'd2;
  localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(RING_DEPTH);
  localparam logic signed [SAMPLE_W-1:0] SMAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SMIN = 24'sh800000;

  localparam logic [CFG_IDX_W-1:0] REG_RING_LENGTH   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 1'd1;

  localparam logic [CMD_W-1:0] CMD_NONE      = 4'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 4'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD      = 4'd2;
  localparam logic [CMD_W-1:0] CMD_DIV_ADDR  = 4'd3;
  localparam logic [CMD_W-1:0] CMD_DIV_POS   = 4'd4;
  localparam logic [CMD_W-1:0] CMD_DIV_PREV  = 4'd5;
  localparam logic [CMD_W-1:0] CMD_DIV_AVG   = 4'd6;
  localparam logic [CMD_W-1:0] CMD_DIV_STEP  = 4'd7;
  localparam logic [CMD_W-1:0] CMD_READ_ADDR = 4'd8;
  localparam logic [CMD_W-1:0] CMD_TAKE_POS  = 4'd9;
  localparam logic [CMD_W-1:0] CMD_TAKE_PREV = 4'd10;
  localparam logic [CMD_W-1:0] CMD_DECIDE    = 4'd11;
  localparam logic [CMD_W-1:0] CMD_TAKE_AVG  = 4'd12;
  localparam logic [CMD_W-1:0] CMD_TAKE_STEP = 4'd13;
  localparam logic [CMD_W-1:0] CMD_CELL_RD   = 4'd14;
  localparam logic [CMD_W-1:0] CMD_CELL_WR   = 4'd15;

  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             mul;
    logic             out;
  } irwh_cmd_t;

  typedef struct packed {
    logic div_done;
    logic clr_last;
    logic is_read;
    logic head_active;
    logic last_act;
    logic same_pos;
    logic cell_last;
    logic out_free;
  } irwh_stat_t;

endpackage

>>> rtl/irwh_div.sv
// Bit-serial restoring divider that yields one quotient bit per cycle.
`timescale 1ns / 1ps
module irwh_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [irwh_pkg::DIV_W-1:0]   dividend_i,
  input  logic [irwh_pkg::DIVR_W-1:0]  divisor_i,
  output logic                         done_o,
  output logic [irwh_pkg::DIV_W-1:0]   quot_o,
  output logic [irwh_pkg::DIVR_W-1:0]  rem_o
);
  import irwh_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [DIV_W-1:0]  quo_q;
  logic [DIVR_W-1:0] rem_q;
  logic [DIVR_W-1:0] dsr_q;
  logic [DIVR_W:0]   shifted;
  logic [DIVR_W:0]   trial;
  logic              ge;

  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign ge      = shifted >= {1'b0, dsr_q};
  assign trial   = shifted - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_W-2:0], ge};
      rem_q <= ge ? trial[DIVR_W-1:0] : shifted[DIVR_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;
endmodule

>>> rtl/irwh_datapath.sv
// Datapath: configuration, head state, ring memory, fill arithmetic and result register.
`timescale 1ns / 1ps
module irwh_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  irwh_pkg::irwh_cmd_t                 cmd_i,
  output irwh_pkg::irwh_stat_t                stat_o,
  input  logic                                cfg_valid_i,
  input  logic [irwh_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [irwh_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                req_type_i,
  input  logic                                head_active_i,
  input  logic [15:0]                         head_position_i,
  input  logic signed [irwh_pkg::SAMPLE_W-1:0] sample_value_i,
  input  logic [15:0]                         read_address_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                resp_type_o,
  output logic signed [irwh_pkg::SAMPLE_W-1:0] read_data_o,
  output logic [16:0]                         cells_written_o
);
  import irwh_pkg::*;

  logic [LEN_W-1:0]  len_q;
  logic [GAIN_W-1:0] gain_q;
  logic [LEN_W-1:0]  ring_len;

  logic                       rq_read_q, rq_act_q;
  logic [ADDR_W-1:0]          rq_pos_q, rq_addr_q;
  logic signed [SAMPLE_W-1:0] rq_smp_q;

  logic                       last_act_q;
  logic [ADDR_W-1:0]          last_pos_q;
  logic signed [SUM_W-1:0]    sum_q;
  logic [CNT_W-1:0]           cnt_q;
  logic [ADDR_W-1:0]          clr_q;

  logic [ADDR_W-1:0]          pos_q, prev_q, idx_q;
  logic [LEN_W-1:0]           n_q, k_q, cells_q;
  logic                       up_q;
  logic signed [SAMPLE_W-1:0] from_q;
  logic signed [SAMPLE_W:0]   diff_q;
  logic [SAMPLE_W:0]          a_q, qa_q;
  logic [LEN_W-1:0]           b_q, r_q;
  logic signed [40:0]         prod_q;
  logic signed [SAMPLE_W-1:0] rd_q;

  logic                       out_valid_q, resp_q;
  logic signed [SAMPLE_W-1:0] data_q;
  logic [16:0]                owr_q;

  logic signed [SAMPLE_W-1:0] mem [RING_DEPTH];

  logic                div_start, div_done;
  logic [DIV_W-1:0]    div_dvd, div_quo;
  logic [DIVR_W-1:0]   div_dsr, div_rem;
  logic [SUM_W-1:0]    sum_mag;
  logic [SAMPLE_W:0]   diff_mag;

  logic signed [SAMPLE_W:0]   avg_s, avg_f;
  logic [ADDR_W-1:0]          span;
  logic [LEN_W-1:0]           alt;
  logic                       pos_gt;
  logic [LEN_W-1:0]           idx_inc;
  logic [ADDR_W-1:0]          idx_nxt;
  logic [LEN_W:0]             r_sum;
  logic                       carry;
  logic signed [SAMPLE_W+1:0] qs, val;
  logic [40:0]                prod_mag, t_sum;
  logic signed [SAMPLE_W+1:0] term;
  logic signed [SAMPLE_W+2:0] sv;
  logic signed [SAMPLE_W-1:0] wr_val;
  logic                       cell_last;

  logic                       wr_en, rd_en;
  logic [ADDR_W-1:0]          wr_addr, rd_addr;
  logic signed [SAMPLE_W-1:0] wr_data;

  always_comb begin
    if (len_q < LEN_MIN) begin
      ring_len = LEN_MIN;
    end else if (len_q > LEN_MAX) begin
      ring_len = LEN_MAX;
    end else begin
      ring_len = len_q;
    end
  end

  assign sum_mag  = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign diff_mag = diff_q[SAMPLE_W] ? (SAMPLE_W+1)'(-diff_q) : (SAMPLE_W+1)'(diff_q);

  always_comb begin
    div_start = 1'b1;
    div_dvd   = DIV_W'(rq_addr_q);
    div_dsr   = ring_len;
    unique case (cmd_i.op)
      CMD_DIV_ADDR: div_dvd = DIV_W'(rq_addr_q);
      CMD_DIV_POS:  div_dvd = DIV_W'(rq_pos_q);
      CMD_DIV_PREV: div_dvd = DIV_W'(last_pos_q);
      CMD_DIV_AVG: begin
        div_dvd = sum_mag + DIV_W'(cnt_q[CNT_W-1:1]);
        div_dsr = DIVR_W'(cnt_q);
      end
      CMD_DIV_STEP: begin
        div_dvd = DIV_W'(diff_mag);
        div_dsr = n_q;
      end
      default: div_start = 1'b0;
    endcase
  end

  irwh_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quot_o     (div_quo),
    .rem_o      (div_rem)
  );

  assign avg_s = {1'b0, div_quo[SAMPLE_W-1:0]};
  always_comb begin
    if (cnt_q == '0) begin
      avg_f = '0;
    end else if (sum_q[SUM_W-1]) begin
      avg_f = -avg_s;
    end else begin
      avg_f = avg_s;
    end
  end

  assign pos_gt = pos_q > prev_q;
  assign span   = pos_gt ? pos_q - prev_q : prev_q - pos_q;
  assign alt    = ring_len - LEN_W'(span);

  assign idx_inc = LEN_W'(idx_q) + 1'b1;
  always_comb begin
    if (up_q) begin
      idx_nxt = (idx_inc == ring_len) ? '0 : idx_inc[ADDR_W-1:0];
    end else begin
      idx_nxt = (idx_q == '0) ? ADDR_W'(ring_len - 1'b1) : idx_q - 1'b1;
    end
  end

  assign r_sum = {1'b0, r_q} + {1'b0, b_q};
  assign carry = r_sum >= {1'b0, n_q};

  assign qs  = {1'b0, qa_q};
  assign val = {{2{from_q[SAMPLE_W-1]}}, from_q} + (diff_q[SAMPLE_W] ? -qs : qs);

  assign prod_mag = prod_q[40] ? 41'(-prod_q) : 41'(prod_q);
  assign t_sum    = prod_mag + 41'd32768;
  assign term     = prod_q[40] ? -$signed({1'b0, t_sum[40:16]}) : $signed({1'b0, t_sum[40:16]});
  assign sv       = {val[SAMPLE_W+1], val} + {term[SAMPLE_W+1], term};

  always_comb begin
    if (sv > (SAMPLE_W+3)'(SMAX)) begin
      wr_val = SMAX;
    end else if (sv < (SAMPLE_W+3)'(SMIN)) begin
      wr_val = SMIN;
    end else begin
      wr_val = sv[SAMPLE_W-1:0];
    end
  end

  assign cell_last = k_q == (n_q - 1'b1);

  assign wr_en   = (cmd_i.op == CMD_CLEAR) || (cmd_i.op == CMD_CELL_WR);
  assign wr_addr = (cmd_i.op == CMD_CLEAR) ? clr_q : idx_q;
  assign wr_data = (cmd_i.op == CMD_CLEAR) ? '0 : wr_val;
  assign rd_en   = (cmd_i.op == CMD_READ_ADDR) || (cmd_i.op == CMD_CELL_RD);
  assign rd_addr = (cmd_i.op == CMD_READ_ADDR) ? div_rem[ADDR_W-1:0] : idx_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= LEN_MAX;
      gain_q      <= '0;
      last_act_q  <= 1'b0;
      last_pos_q  <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_RING_LENGTH:   len_q  <= cfg_data_i;
          REG_FEEDBACK_GAIN: gain_q <= (cfg_data_i[GAIN_W-1:0] > FB_MAX) ?
                                       FB_MAX : cfg_data_i[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i.op)
        CMD_CLEAR: clr_q <= clr_q + 1'b1;
        CMD_TAKE_POS: begin
          if (!last_act_q) begin
            last_act_q <= 1'b1;
            sum_q      <= '0;
            cnt_q      <= '0;
          end
        end
        CMD_DECIDE: begin
          if (pos_q == prev_q) begin
            last_pos_q <= pos_q;
            if (cnt_q < CNT_MAX) begin
              sum_q <= sum_q + SUM_W'(rq_smp_q);
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        CMD_CELL_WR: begin
          if (cell_last) begin
            if (rq_act_q) begin
              sum_q      <= SUM_W'(rq_smp_q);
              cnt_q      <= CNT_W'(1);
              last_pos_q <= pos_q;
            end else begin
              sum_q      <= '0;
              cnt_q      <= '0;
              last_act_q <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= rd_q * $signed({1'b0, gain_q});
    end
    if (cmd_i.out) begin
      resp_q <= rq_read_q;
      data_q <= rq_read_q ? rd_q : '0;
      owr_q  <= rq_read_q ? '0 : cells_q;
    end
    unique case (cmd_i.op)
      CMD_LOAD: begin
        rq_read_q <= req_type_i;
        rq_act_q  <= head_active_i;
        rq_pos_q  <= head_position_i;
        rq_smp_q  <= sample_value_i;
        rq_addr_q <= read_address_i;
        cells_q   <= '0;
      end
      CMD_TAKE_POS: begin
        pos_q <= div_rem[ADDR_W-1:0];
        if (!last_act_q) begin
          prev_q <= div_rem[ADDR_W-1:0];
        end
      end
      CMD_TAKE_PREV: begin
        prev_q <= div_rem[ADDR_W-1:0];
        idx_q  <= div_rem[ADDR_W-1:0];
        n_q    <= LEN_W'(1);
        k_q    <= '0;
        qa_q   <= '0;
        a_q    <= '0;
        b_q    <= '0;
        r_q    <= '0;
      end
      CMD_DECIDE: begin
        idx_q <= prev_q;
        if (LEN_W'(span) > alt) begin
          n_q  <= alt;
          up_q <= !pos_gt;
        end else begin
          n_q  <= LEN_W'(span);
          up_q <= pos_gt;
        end
      end
      CMD_TAKE_AVG: begin
        from_q <= avg_f[SAMPLE_W-1:0];
        diff_q <= {rq_smp_q[SAMPLE_W-1], rq_smp_q} - avg_f;
      end
      CMD_TAKE_STEP: begin
        a_q  <= div_quo[SAMPLE_W:0];
        b_q  <= div_rem;
        qa_q <= '0;
        r_q  <= n_q >> 1;
        k_q  <= '0;
      end
      CMD_CELL_WR: begin
        idx_q <= idx_nxt;
        k_q   <= k_q + 1'b1;
        qa_q  <= qa_q + a_q + (SAMPLE_W+1)'(carry);
        r_q   <= carry ? LEN_W'(r_sum - {1'b0, n_q}) : r_sum[LEN_W-1:0];
        if (cell_last) begin
          cells_q <= n_q;
        end
      end
      default: ;
    endcase
  end

  assign stat_o.div_done    = div_done;
  assign stat_o.clr_last    = &clr_q;
  assign stat_o.is_read     = rq_read_q;
  assign stat_o.head_active = rq_act_q;
  assign stat_o.last_act    = last_act_q;
  assign stat_o.same_pos    = pos_q == prev_q;
  assign stat_o.cell_last   = cell_last;
  assign stat_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign resp_type_o     = resp_q;
  assign read_data_o     = data_q;
  assign cells_written_o = owr_q;
endmodule

>>> rtl/irwh_ctrl.sv
// Controller state machine that sequences clearing, divisions and cell fills.
`timescale 1ns / 1ps
module irwh_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  irwh_pkg::irwh_stat_t stat_i,
  output irwh_pkg::irwh_cmd_t  cmd_o
);
  import irwh_pkg::*;

  localparam logic [4:0] S_CLEAR    = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_ROUTE    = 5'd2;
  localparam logic [4:0] S_ADDR_GO  = 5'd3;
  localparam logic [4:0] S_ADDR_WT  = 5'd4;
  localparam logic [4:0] S_ADDR_RD  = 5'd5;
  localparam logic [4:0] S_POS_GO   = 5'd6;
  localparam logic [4:0] S_POS_WT   = 5'd7;
  localparam logic [4:0] S_POS_TK   = 5'd8;
  localparam logic [4:0] S_PREV_GO  = 5'd9;
  localparam logic [4:0] S_PREV_WT  = 5'd10;
  localparam logic [4:0] S_PREV_TK  = 5'd11;
  localparam logic [4:0] S_DECIDE   = 5'd12;
  localparam logic [4:0] S_AVG_GO   = 5'd13;
  localparam logic [4:0] S_AVG_WT   = 5'd14;
  localparam logic [4:0] S_AVG_TK   = 5'd15;
  localparam logic [4:0] S_STEP_GO  = 5'd16;
  localparam logic [4:0] S_STEP_WT  = 5'd17;
  localparam logic [4:0] S_STEP_TK  = 5'd18;
  localparam logic [4:0] S_CELL_RD  = 5'd19;
  localparam logic [4:0] S_CELL_MUL = 5'd20;
  localparam logic [4:0] S_CELL_WR  = 5'd21;
  localparam logic [4:0] S_OUT      = 5'd22;

  logic [4:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = CMD_NONE;
    cmd_o.mul  = 1'b0;
    cmd_o.out  = 1'b0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.op = CMD_CLEAR;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = CMD_LOAD;
          state_d  = S_ROUTE;
        end
      end
      S_ROUTE: begin
        if (stat_i.is_read) begin
          state_d = S_ADDR_GO;
        end else if (stat_i.head_active) begin
          state_d = S_POS_GO;
        end else if (stat_i.last_act) begin
          state_d = S_PREV_GO;
        end else begin
          state_d = S_OUT;
        end
      end
      S_ADDR_GO: begin
        cmd_o.op = CMD_DIV_ADDR;
        state_d  = S_ADDR_WT;
      end
      S_ADDR_WT: if (stat_i.div_done) state_d = S_ADDR_RD;
      S_ADDR_RD: begin
        cmd_o.op = CMD_READ_ADDR;
        state_d  = S_OUT;
      end
      S_POS_GO: begin
        cmd_o.op = CMD_DIV_POS;
        state_d  = S_POS_WT;
      end
      S_POS_WT: if (stat_i.div_done) state_d = S_POS_TK;
      S_POS_TK: begin
        cmd_o.op = CMD_TAKE_POS;
        state_d  = stat_i.last_act ? S_PREV_GO : S_DECIDE;
      end
      S_PREV_GO: begin
        cmd_o.op = CMD_DIV_PREV;
        state_d  = S_PREV_WT;
      end
      S_PREV_WT: if (stat_i.div_done) state_d = S_PREV_TK;
      S_PREV_TK: begin
        cmd_o.op = CMD_TAKE_PREV;
        state_d  = stat_i.head_active ? S_DECIDE : S_AVG_GO;
      end
      S_DECIDE: begin
        cmd_o.op = CMD_DECIDE;
        state_d  = stat_i.same_pos ? S_OUT : S_AVG_GO;
      end
      S_AVG_GO: begin
        cmd_o.op = CMD_DIV_AVG;
        state_d  = S_AVG_WT;
      end
      S_AVG_WT: if (stat_i.div_done) state_d = S_AVG_TK;
      S_AVG_TK: begin
        cmd_o.op = CMD_TAKE_AVG;
        state_d  = stat_i.head_active ? S_STEP_GO : S_CELL_RD;
      end
      S_STEP_GO: begin
        cmd_o.op = CMD_DIV_STEP;
        state_d  = S_STEP_WT;
      end
      S_STEP_WT: if (stat_i.div_done) state_d = S_STEP_TK;
      S_STEP_TK: begin
        cmd_o.op = CMD_TAKE_STEP;
        state_d  = S_CELL_RD;
      end
      S_CELL_RD: begin
        cmd_o.op = CMD_CELL_RD;
        state_d  = S_CELL_MUL;
      end
      S_CELL_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_CELL_WR;
      end
      S_CELL_WR: begin
        cmd_o.op = CMD_CELL_WR;
        state_d  = stat_i.cell_last ? S_OUT : S_CELL_RD;
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

>>> rtl/interpolating_ring_write_head.sv
// Top level of the interpolating ring write head.
// After reset the ring is zeroed one cell a cycle, all 65536 cells; in_ready_o stays low.
// Each modulo, average or fill step uses the shared bit-serial divider.
// A read item takes one division and a memory read; a sample item takes 0 to 4 divisions
// plus, per filled cell, a memory read, a feedback multiply and a write.
// One item is in work at a time; the result register frees the input while a result waits.
`timescale 1ns / 1ps
module interpolating_ring_write_head (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [irwh_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [irwh_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 req_type_i,
  input  logic                                 head_active_i,
  input  logic [15:0]                          head_position_i,
  input  logic signed [irwh_pkg::SAMPLE_W-1:0] sample_value_i,
  input  logic [15:0]                          read_address_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 resp_type_o,
  output logic signed [irwh_pkg::SAMPLE_W-1:0] read_data_o,
  output logic [16:0]                          cells_written_o
);
  import irwh_pkg::*;

  irwh_cmd_t  cmd;
  irwh_stat_t stat;

  assign cfg_ready_o = 1'b1;

  irwh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  irwh_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .req_type_i      (req_type_i),
    .head_active_i   (head_active_i),
    .head_position_i (head_position_i),
    .sample_value_i  (sample_value_i),
    .read_address_i  (read_address_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .resp_type_o     (resp_type_o),
    .read_data_o     (read_data_o),
    .cells_written_o (cells_written_o)
  );
endmodule

>>> rtl/irwh_checker.sv
// Port-level checker for the interpolating ring write head and its bind.
`timescale 1ns / 1ps
module irwh_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_o,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic                                 resp_type_o,
  input logic signed [irwh_pkg::SAMPLE_W-1:0] read_data_o,
  input logic [16:0]                          cells_written_o
);

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while an item is in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(read_data_o) && $stable(cells_written_o)
                                    && $stable(resp_type_o))
    else $error("stalled result changed");

  a_read_no_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && resp_type_o |-> cells_written_o == '0)
    else $error("read result reports written cells");

  a_sample_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !resp_type_o |-> read_data_o == '0)
    else $error("sample result carries read data");
endmodule

bind interpolating_ring_write_head irwh_checker u_irwh_checker (.*);

>>> bench/testbench.sv
// Self-checking testbench for the interpolating ring write head with a ring-store predictor.
`timescale 1ns / 1ps
module testbench;
  import irwh_pkg::*;

  typedef struct {
    bit               is_read;
    bit               active;
    bit [15:0]        position;
    bit signed [23:0] sample;
    bit [15:0]        address;
  } head_item_t;

  typedef struct {
    bit               resp_type;
    bit signed [23:0] read_data;
    bit [16:0]        cells_written;
  } head_result_t;

  class ring_scoreboard;
    logic signed [23:0] cells [0:65535];
    int unsigned        length_reg;
    int unsigned        gain;
    int unsigned        last_pos;
    bit                 last_act;
    longint             acc_sum;
    int unsigned        acc_count;
    head_result_t       expected_q [$];
    int                 mismatches;

    function new();
      for (int i = 0; i < 65536; i++) cells[i] = '0;
      length_reg = 65536;
      gain = 0;
      last_pos = 0;
      last_act = 0;
      acc_sum = 0;
      acc_count = 0;
      mismatches = 0;
    endfunction

    function void set_reg(bit [CFG_IDX_W-1:0] idx, bit [16:0] data);
      if (idx == REG_RING_LENGTH) length_reg = data;
      else gain = (data[15:0] > FB_MAX) ? FB_MAX : data[15:0];
    endfunction

    function longint round_div(longint num, longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
    endfunction

    function void store(int unsigned idx, longint value);
      longint v;
      v = value + round_div(longint'(cells[idx]) * longint'(gain), 65536);
      if (v > longint'(SMAX)) v = SMAX;
      if (v < longint'(SMIN)) v = SMIN;
      cells[idx] = v[23:0];
    endfunction

    function longint mean();
      if (acc_count == 0) return 0;
      return round_div(acc_sum, acc_count);
    endfunction

    function void note_input(head_item_t it);
      head_result_t r;
      int unsigned ring_len, pos, prev, span, alt, n, idx;
      bit up;
      longint from, diff;
      ring_len = length_reg < 2 ? 2 : (length_reg > 65536 ? 65536 : length_reg);
      r = '{default: '0};
      if (it.is_read) begin
        r.resp_type = 1;
        r.read_data = cells[it.address % ring_len];
      end else if (!it.active) begin
        if (last_act) begin
          store(last_pos % ring_len, mean());
          r.cells_written = 1;
          acc_sum = 0;
          acc_count = 0;
          last_act = 0;
        end
      end else begin
        pos = it.position % ring_len;
        prev = last_pos % ring_len;
        if (!last_act) begin
          last_act = 1;
          prev = pos;
          acc_sum = 0;
          acc_count = 0;
        end
        if (pos == prev) begin
          if (acc_count < CNT_MAX) begin
            acc_sum += it.sample;
            acc_count++;
          end
        end else begin
          span = pos > prev ? pos - prev : prev - pos;
          alt = ring_len - span;
          up = pos > prev;
          n = span;
          if (span > alt) begin
            up = !up;
            n = alt;
          end
          from = mean();
          diff = longint'(it.sample) - from;
          idx = prev;
          for (int unsigned k = 0; k < n; k++) begin
            store(idx, from + round_div(diff * longint'(k), n));
            if (up) idx = (idx + 1 == ring_len) ? 0 : idx + 1;
            else idx = (idx == 0) ? ring_len - 1 : idx - 1;
          end
          r.cells_written = n[16:0];
          acc_sum = it.sample;
          acc_count = 1;
        end
        last_pos = pos;
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(head_result_t got);
      head_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result type=%0d", got.resp_type);
        return;
      end
      want = expected_q.pop_front();
      if (got.resp_type != want.resp_type || got.read_data != want.read_data ||
          got.cells_written != want.cells_written) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp type=%0d data=%0d cells=%0d, got type=%0d data=%0d cells=%0d",
                   want.resp_type, want.read_data, want.cells_written,
                   got.resp_type, got.read_data, got.cells_written);
      end
    endfunction
  endclass

  logic                 clk_i = 0;
  logic                 rst_ni = 0;
  logic                 cfg_valid_i = 0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [16:0]          cfg_data_i = '0;
  logic                 in_valid_i = 0;
  logic                 in_ready_o;
  logic                 req_type_i = 0;
  logic                 head_active_i = 0;
  logic [15:0]          head_position_i = '0;
  logic signed [23:0]   sample_value_i = '0;
  logic [15:0]          read_address_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 0;
  logic                 resp_type_o;
  logic signed [23:0]   read_data_o;
  logic [16:0]          cells_written_o;

  ring_scoreboard sb = new();
  bit             steady = 0;
  bit             hold_req = 0;
  int unsigned    gen_pos = 0;
  int unsigned    gen_len = 65536;

  interpolating_ring_write_head u_dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i = 0;
        repeat (600) @(negedge clk_i);
        hold_req = 0;
      end
      out_ready_i = steady ? 1'b1 : ($urandom_range(0, 99) >= 13);
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i)
      sb.check_result('{resp_type_o, read_data_o, cells_written_o});
  end

  task automatic send_item(head_item_t it);
    if (!steady && $urandom_range(0, 99) < 13) begin
      @(negedge clk_i);
      in_valid_i = 0;
      repeat ($urandom_range(0, 4)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1;
    req_type_i = it.is_read;
    head_active_i = it.active;
    head_position_i = it.position;
    sample_value_i = it.sample;
    read_address_i = it.address;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(it);
  endtask

  task automatic write_reg(bit [CFG_IDX_W-1:0] idx, bit [16:0] data);
    @(negedge clk_i);
    in_valid_i = 0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    cfg_valid_i = 1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 0;
    if (idx == REG_RING_LENGTH)
      gen_len = data < 2 ? 2 : (data > 65536 ? 65536 : data);
  endtask

  task automatic put(bit rd, bit act, int unsigned pos, int smp, int unsigned addr = 0);
    send_item('{rd, act, pos[15:0], smp[23:0], addr[15:0]});
  endtask

  task automatic random_items(int count);
    int unsigned sel, step;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (gen_len == 65536) begin
        step = $urandom_range(0, 12);
        gen_pos = (gen_pos + 65536 + step - 6) % 65536;
      end else begin
        gen_pos = $urandom_range(0, 65535);
      end
      if (sel < 12)
        put(1, $urandom, $urandom, $urandom, $urandom);
      else if (sel < 22)
        put(0, 0, $urandom, $urandom, $urandom);
      else if (sel < 40)
        put(0, 1, sb.last_pos, $urandom, $urandom);
      else if (sel < 46)
        put(0, 1, gen_pos, ($urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000), $urandom);
      else
        put(0, 1, gen_pos, $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni = 1;

    put(0, 1, 0, 24'h7FFFFF);
    put(0, 1, 0, 24'h800000);
    put(0, 1, 3, 24'h7FFFFF);
    put(1, 0, 0, 0, 1);
    put(0, 0, 0, 0);
    put(0, 0, 0, 0);
    put(1, 1, 0, 0, 3);
    put(0, 1, 65535, -100);
    put(0, 1, 1, 100);
    put(1, 0, 0, 0, 0);

    write_reg(REG_RING_LENGTH, 16);
    write_reg(REG_FEEDBACK_GAIN, 17'h1FFFF);
    put(0, 1, 0, 24'h7FFFFF);
    put(0, 1, 8, 24'h800000);
    put(0, 1, 15, 24'h7FFFFF);
    put(0, 1, 1, 24'h7FFFFF);
    put(0, 1, 9, 24'h7FFFFF);
    put(0, 1, 1, 24'h7FFFFF);
    put(1, 0, 0, 0, 65535);
    put(0, 0, 0, 0);

    write_reg(REG_RING_LENGTH, 1);
    put(0, 1, 65535, 5);
    put(0, 1, 65534, -7);
    put(1, 0, 0, 0, 65535);

    write_reg(REG_RING_LENGTH, 16);
    random_items(100);
    write_reg(REG_FEEDBACK_GAIN, 0);
    steady = 1;
    random_items(60);
    steady = 0;
    write_reg(REG_RING_LENGTH, 2);
    write_reg(REG_FEEDBACK_GAIN, 62259);
    random_items(100);
    write_reg(REG_RING_LENGTH, 300);
    write_reg(REG_FEEDBACK_GAIN, 30000);
    hold_req = 1;
    random_items(160);
    write_reg(REG_RING_LENGTH, 131071);
    write_reg(REG_FEEDBACK_GAIN, 62258);
    gen_pos = 65530;
    random_items(150);
    write_reg(REG_RING_LENGTH, 65536);
    write_reg(REG_FEEDBACK_GAIN, 1);
    random_items(120);
    write_reg(REG_RING_LENGTH, 37);
    write_reg(REG_FEEDBACK_GAIN, 45000);
    random_items(140);

    @(negedge clk_i);
    in_valid_i = 0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("tb: failure");
    $finish;
  end
endmodule

>>> interpolating_ring_write_head.f
rtl/irwh_pkg.sv
rtl/irwh_div.sv
rtl/irwh_datapath.sv
rtl/irwh_ctrl.sv
rtl/interpolating_ring_write_head.sv
rtl/irwh_checker.sv
bench/testbench.sv
